// ----- src/fwab_pkg.sv -----
// Shared types and constants for the full-width to ASCII byte filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fwab_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned MaxOut     = 6;
  localparam int unsigned LenW       = 3;
  localparam int unsigned QueueDepth = 4;

  localparam logic [ByteW-1:0] ByteWide     = 8'd239;
  localparam logic [ByteW-1:0] ByteCjk      = 8'd227;
  localparam logic [ByteW-1:0] ByteMid      = 8'd128;
  localparam logic [ByteW-1:0] ByteCjkComma = 8'd129;
  localparam logic [ByteW-1:0] ByteCjkStop  = 8'd130;
  localparam logic [ByteW-1:0] DigitOffset  = 8'd96;
  localparam logic [ByteW-1:0] CommaOffset  = 8'd85;
  localparam logic [ByteW-1:0] StopOffset   = 8'd84;
  localparam logic [ByteW-1:0] ByteNewline  = 8'd10;
  localparam logic [ByteW-1:0] ByteSpace    = 8'd32;
  localparam logic [ByteW-1:0] ByteComma    = 8'd44;

  // Configuration register indexes
  localparam logic RegDigitEn = 1'b0;
  localparam logic RegPunctEn = 1'b1;

  // All output bytes caused by one input word
  typedef struct packed {
    logic [MaxOut-1:0][ByteW-1:0] bytes;
    logic [LenW-1:0]              len;
  } fwab_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fwab_qstat_t;

endpackage

// ----- src/fwab_front.sv -----
// Front end: accepts input words, runs the digit and punctuation stages and
// the comma spacing, and hands each non-empty item to the queue. Uses fwab_pkg.
`timescale 1ns / 1ps

module fwab_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output fwab_pkg::fwab_item_t q_item_o
);
  import fwab_pkg::*;

  typedef struct packed {
    logic [1:0]            cnt;
    logic [1:0]            n;
    logic [2:0][ByteW-1:0] b;
  } s2_res_t;

  localparam int unsigned PreN = 9;
  localparam int unsigned PreW = $clog2(PreN + 1);

  logic            digit_en_q, punct_en_q;
  logic [1:0]      wc_q, wc_d, pc_q, pc_d;
  logic [ByteW-1:0] ws_q, ws_d;
  logic            accept;

  s2_res_t                   r_a, r_b;
  logic [PreN-1:0][ByteW-1:0] pre;
  logic [PreW-1:0]           pn;
  logic [1:0]                pc_v;
  fwab_item_t                item;

  // One byte into the punctuation stage: new count and up to three bytes out
  function automatic s2_res_t s2_feed(input logic [1:0] cnt, input logic en,
                                      input logic [ByteW-1:0] b);
    s2_res_t r;
    logic    starts;
    r      = '0;
    starts = en && (b == ByteCjk);
    if (cnt == 2'd0) begin
      if (starts) r.cnt = 2'd1;
      else begin
        r.n    = 2'd1;
        r.b[0] = b;
      end
    end else if (cnt == 2'd1) begin
      if (b == ByteMid) r.cnt = 2'd2;
      else begin
        r.b[0] = ByteCjk;
        if (starts) begin
          r.cnt = 2'd1;
          r.n   = 2'd1;
        end else begin
          r.b[1] = b;
          r.n    = 2'd2;
        end
      end
    end else begin
      if (b == ByteCjkComma) begin
        r.b[0] = ByteCjkComma - CommaOffset;
        r.n    = 2'd1;
      end else if (b == ByteCjkStop) begin
        r.b[0] = ByteCjkStop - StopOffset;
        r.n    = 2'd1;
      end else begin
        r.b[0] = ByteCjk;
        r.b[1] = ByteMid;
        if (starts) begin
          r.cnt = 2'd1;
          r.n   = 2'd2;
        end else begin
          r.b[2] = b;
          r.n    = 2'd3;
        end
      end
    end
    return r;
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    r_a  = '0;
    r_b  = '0;
    pre  = '0;
    pn   = '0;
    pc_v = pc_q;
    wc_d = wc_q;
    ws_d = ws_q;
    if (in_byte_i == ByteNewline) begin
      // flush stage one into stage two, then stage two out, then the newline
      if (wc_q != 2'd0) begin
        r_a  = s2_feed(pc_v, punct_en_q, ByteWide);
        pc_v = r_a.cnt;
        if (wc_q[1]) begin
          r_b  = s2_feed(pc_v, punct_en_q, ws_q);
          pc_v = r_b.cnt;
        end
      end
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < r_a.n) begin
          pre[pn] = r_a.b[k];
          pn      = pn + PreW'(1);
        end
      end
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < r_b.n) begin
          pre[pn] = r_b.b[k];
          pn      = pn + PreW'(1);
        end
      end
      if (pc_v != 2'd0) begin
        pre[pn] = ByteCjk;
        pn      = pn + PreW'(1);
        if (pc_v[1]) begin
          pre[pn] = ByteMid;
          pn      = pn + PreW'(1);
        end
      end
      pre[pn] = ByteNewline;
      pn      = pn + PreW'(1);
      pc_v    = 2'd0;
      wc_d    = 2'd0;
    end else begin
      if (wc_q == 2'd0) begin
        if (digit_en_q && (in_byte_i == ByteWide)) wc_d = 2'd1;
        else r_a = s2_feed(pc_v, punct_en_q, in_byte_i);
      end else if (wc_q == 2'd1) begin
        ws_d = in_byte_i;
        wc_d = 2'd2;
      end else begin
        wc_d = 2'd0;
        r_a  = s2_feed(pc_v, punct_en_q, in_byte_i - DigitOffset);
      end
      if (wc_q != 2'd1 && !(wc_q == 2'd0 && digit_en_q && in_byte_i == ByteWide)) begin
        pc_v = r_a.cnt;
      end
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < r_a.n) begin
          pre[pn] = r_a.b[k];
          pn      = pn + PreW'(1);
        end
      end
    end
    pc_d = pc_v;

    // comma spacing, capped at the item size
    item = '0;
    for (int i = 0; i < PreN; i++) begin
      if (PreW'(i) < pn) begin
        if (item.len < LenW'(MaxOut)) begin
          item.bytes[item.len] = pre[i];
          item.len             = item.len + LenW'(1);
        end
        if (pre[i] == ByteComma && item.len < LenW'(MaxOut)) begin
          item.bytes[item.len] = ByteSpace;
          item.len             = item.len + LenW'(1);
        end
      end
    end
  end

  assign q_push_o = accept && (item.len != '0);
  assign q_item_o = item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_en_q <= 1'b1;
      punct_en_q <= 1'b1;
      wc_q       <= 2'd0;
      pc_q       <= 2'd0;
      ws_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegDigitEn) digit_en_q <= cfg_wdata_i;
        if (cfg_idx_i == RegPunctEn) punct_en_q <= cfg_wdata_i;
      end
      if (accept) begin
        wc_q <= wc_d;
        pc_q <= pc_d;
        ws_q <= ws_d;
      end
    end
  end

endmodule

// ----- src/fwab_queue.sv -----
// Short item queue between front and back end; decouples their stalls.
// Uses fwab_pkg for the item type.
`timescale 1ns / 1ps

module fwab_queue #(
  parameter int unsigned Depth = fwab_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  fwab_pkg::fwab_item_t push_item_i,
  input  logic                 pop_i,
  output fwab_pkg::fwab_item_t pop_item_o,
  output fwab_pkg::fwab_qstat_t stat_o
);
  import fwab_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  fwab_item_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) count_q <= count_q + CntW'(1);
      else if (pop_i && !push_i) count_q <= count_q - CntW'(1);
    end
  end

endmodule

// ----- src/fwab_back.sv -----
// Back end: takes items from the queue and sends their bytes one word a cycle
// while the output is ready, marking each item's last byte. Uses fwab_pkg for items.
`timescale 1ns / 1ps

module fwab_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  fwab_pkg::fwab_item_t q_item_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o
);
  import fwab_pkg::*;

  fwab_item_t       cur_q;
  logic [LenW-1:0]  idx_q;
  logic             valid_q;
  logic             last;
  logic             load;

  assign last        = (idx_q == cur_q.len - LenW'(1));
  assign load        = !q_empty_i && (!valid_q || (out_ready_i && last));
  assign q_pop_o     = load;
  assign out_valid_o = valid_q;
  assign out_byte_o  = cur_q.bytes[idx_q];
  assign out_last_o  = last;

  always_ff @(posedge clk_i) begin
    if (load) cur_q <= q_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (valid_q && out_ready_i) begin
      if (last) valid_q <= 1'b0;
      else idx_q <= idx_q + LenW'(1);
    end
  end

endmodule

// ----- src/fullwidth_to_ascii_byte_filter_unit.sv -----
// Full-width to ASCII byte filter: with the queue and back end idle, the first
// output word of an input word is registered in the queue, then in the back end.
// One input word is taken per cycle while the queue has room; each input yields
// 0 to 6 output words, sent one per ready cycle by the back end, so words with at
// most one output each stream at one per cycle and longer runs stall the input.
// Reset clears all sequence counts, empties the queue and sets both enables.
`timescale 1ns / 1ps

module fullwidth_to_ascii_byte_filter_unit #(
  parameter int unsigned QueueDepth = fwab_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write port: index 0 digit enable, index 1 punctuation enable
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic       cfg_wdata_i,
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  // output stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // last_of_run
);
  import fwab_pkg::*;

  logic        q_push, q_pop;
  fwab_item_t  q_in_item, q_out_item;
  fwab_qstat_t q_stat;

  // Front: classify each word through the digit and punctuation stages and
  // build the full list of output bytes it causes in the same cycle.
  fwab_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .q_full_i   (q_stat.full),
    .q_push_o   (q_push),
    .q_item_o   (q_in_item)
  );

  // Queue: hold items so a stalled output does not stop the front at once.
  fwab_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_item_i(q_in_item),
    .pop_i      (q_pop),
    .pop_item_o (q_out_item),
    .stat_o     (q_stat)
  );

  // Back: serialize each item, advancing on every accepted output word.
  fwab_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_stat.empty),
    .q_item_i   (q_out_item),
    .q_pop_o    (q_pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_byte_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full) else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty) else $error("pop from empty queue");

  a_newline_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tdata == ByteNewline) |-> q_push)
    else $error("newline produced no output");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> !s_axis_tready) else $error("input taken while queue full");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for fullwidth_to_ascii_byte_filter_unit: directed table
// and random text streams, checked word by word against an in-bench predictor.
// Depends on fwab_pkg (byte constants, register indexes) and the unit itself.
`timescale 1ns / 1ps

module tb;
  import fwab_pkg::*;

  localparam int unsigned HalfPeriod = 10;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 120;
  // Settle time after the last output word before a register write or the end.
  localparam int unsigned DrainCycles = 8;
  // Row count value meaning "take the expected words from the predictor".
  localparam logic [3:0] Predicted = 4'hF;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  // One directed row: input byte, count of typed-in output words, and the
  // words themselves with the first one in the lowest byte.
  typedef struct packed {
    logic [7:0]      data;
    logic [3:0]      count;
    logic [5:0][7:0] words;
  } dir_row_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic       cfg_idx_i     = 1'b0;
  logic       cfg_wdata_i   = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  fullwidth_to_ascii_byte_filter_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte
    .m_axis_tlast  (m_axis_tlast)    // last_of_run
  );

  always #HalfPeriod clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor state: mirror of the enables and of both sequence holders.
  // --------------------------------------------------------------------------
  logic       digit_en  = 1'b1;
  logic       punct_en  = 1'b1;
  logic [1:0] wide_cnt  = 2'd0;
  logic [7:0] wide_x    = 8'h00;
  logic [1:0] punct_cnt = 2'd0;
  logic [7:0] run_q [$];          // words caused by the input being predicted

  out_word_t  filtered_q [$];     // expected output words, oldest first
  int         mismatch_cnt = 0;
  int         cycle_cnt    = 0;
  int         holds_asked  = 0;
  int         burst_left   = 0;

  // Comma expansion: every comma leaving the chain drags a space along.
  function automatic void emit_text(input logic [7:0] b);
    run_q.push_back(b);
    if (b == ByteComma) run_q.push_back(ByteSpace);
  endfunction

  // Punctuation stage with nothing held; a broken sequence re-enters here.
  function automatic void punct_idle(input logic [7:0] b);
    if (punct_en && b == ByteCjk) punct_cnt = 2'd1;
    else emit_text(b);
  endfunction

  function automatic void punct_stage(input logic [7:0] b);
    case (punct_cnt)
      2'd0: begin
        punct_idle(b);
      end
      2'd1: begin
        if (b == ByteMid) begin
          punct_cnt = 2'd2;
        end else begin
          // lone lead byte: pass it on, then look at b afresh
          punct_cnt = 2'd0;
          emit_text(ByteCjk);
          punct_idle(b);
        end
      end
      default: begin
        // count 3 never occurs but behaves like 2
        punct_cnt = 2'd0;
        if (b == ByteCjkComma) begin
          emit_text(8'(ByteCjkComma - CommaOffset));
        end else if (b == ByteCjkStop) begin
          emit_text(8'(ByteCjkStop - StopOffset));
        end else begin
          emit_text(ByteCjk);
          emit_text(ByteMid);
          punct_idle(b);
        end
      end
    endcase
  endfunction

  // Work out the output words of one accepted input byte into run_q.
  function automatic void predict_filter(input logic [7:0] b);
    logic [1:0] held;
    run_q.delete();
    if (b == ByteNewline) begin
      // flush the wide holder into the punctuation stage, then flush that
      held     = wide_cnt;
      wide_cnt = 2'd0;
      if (held != 2'd0) punct_stage(ByteWide);
      if (held >= 2'd2) punct_stage(wide_x);
      if (punct_cnt != 2'd0) begin
        emit_text(ByteCjk);
        if (punct_cnt >= 2'd2) emit_text(ByteMid);
      end
      punct_cnt = 2'd0;
      emit_text(b);
    end else begin
      case (wide_cnt)
        2'd0: begin
          if (digit_en && b == ByteWide) wide_cnt = 2'd1;
          else punct_stage(b);
        end
        2'd1: begin
          // any byte but a line end is taken as the middle byte, the wide lead included
          wide_x   = b;
          wide_cnt = 2'd2;
        end
        default: begin
          wide_cnt = 2'd0;
          punct_stage(8'(b - DigitOffset));
        end
      endcase
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offer one word, hold it until accepted, queue its expectations.
  // Gaps fall between bursts of random length; some bursts follow with no gap.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [7:0] d, input logic [3:0] count,
                           input logic [5:0][7:0] words);
    int gap;
    int k;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    // accepted at this edge: advance the predictor in step with the unit
    predict_filter(d);
    if (count == Predicted) begin
      for (k = 0; k < run_q.size(); k++)
        filtered_q.push_back('{data: run_q[k], last: (k == run_q.size() - 1)});
    end else begin
      for (k = 0; k < count; k++)
        filtered_q.push_back('{data: words[k], last: (k == count - 1)});
    end
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every expected word is out, plus settle time
  // for any sequence still being worked on inside the unit.
  task automatic drain_output();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // One register write; the predictor takes the new value at the same time.
  task automatic write_reg(input logic idx, input logic val);
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegDigitEn) digit_en = val;
    else punct_en = val;
    @(negedge clk_i);
  endtask

  // Random text: mostly well-formed wide digits and ideographic punctuation
  // with random content, mixed with cut and broken sequences and plain noise.
  task automatic send_random_text(input int count);
    logic [7:0] seq [$];
    int         kind;
    int         sent;
    int         k;
    sent = 0;
    while (sent < count) begin
      seq.delete();
      kind = $urandom_range(0, 15);
      case (kind)
        0, 1, 2: begin
          seq.push_back(ByteWide);
          seq.push_back(($urandom_range(0, 1) == 1) ? 8'hBC : 8'($urandom));
          seq.push_back(($urandom_range(0, 2) != 0) ? 8'($urandom_range(8'h90, 8'h99))
                                                     : 8'($urandom));
        end
        3, 4: begin
          seq.push_back(ByteCjk);
          seq.push_back(ByteMid);
          seq.push_back(($urandom_range(0, 1) == 1) ? ByteCjkComma : ByteCjkStop);
        end
        5: begin
          // wide sequence whose converted byte opens a punctuation sequence
          seq.push_back(ByteWide);
          seq.push_back(8'($urandom));
          seq.push_back(8'(ByteCjk + DigitOffset));
          seq.push_back(ByteMid);
          seq.push_back(($urandom_range(0, 1) == 1) ? ByteCjkComma : ByteCjkStop);
        end
        6: begin
          seq.push_back(ByteCjk);
          seq.push_back(8'($urandom));
        end
        7: begin
          seq.push_back(ByteCjk);
          seq.push_back(ByteMid);
          seq.push_back(8'($urandom));
        end
        8: seq.push_back(ByteNewline);
        9: seq.push_back(ByteComma);
        10: begin
          // sequence cut off by a line end
          case ($urandom_range(0, 3))
            0: seq.push_back(ByteWide);
            1: begin
              seq.push_back(ByteWide);
              seq.push_back(8'($urandom));
            end
            2: seq.push_back(ByteCjk);
            default: begin
              seq.push_back(ByteCjk);
              seq.push_back(ByteMid);
            end
          endcase
          seq.push_back(ByteNewline);
        end
        11, 12, 13: seq.push_back(8'($urandom_range(8'h20, 8'h7E)));
        default: seq.push_back(8'($urandom));
      endcase
      for (k = 0; k < seq.size(); k++) begin
        send_word(seq[k], Predicted, '0);
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall on random patterns that change after random spans; on request
  // hold off for a long stretch so the unit fills up and stalls its input.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int mode;
    int span;
    int holds_done;
    holds_done = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 40);
      repeat (span) begin
        @(negedge clk_i);
        if (holds_done != holds_asked) begin
          holds_done++;
          m_axis_tready <= 1'b0;
          repeat (HoldCycles) @(negedge clk_i);
        end
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ~m_axis_tready;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare each accepted output word with the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_out
    out_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected output word: expected none, got %02h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
        mismatch_cnt++;
      end else begin
        want = filtered_q.pop_front();
        if (m_axis_tdata !== want.data) begin
          $display("%0t: out_byte mismatch: expected %02h, got %02h",
                   $time, want.data, m_axis_tdata);
          mismatch_cnt++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last_of_run mismatch on %02h: expected %b, got %b",
                   $time, want.data, want.last, m_axis_tlast);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed table, then random phases over all enable
  // settings, with register writes only while the unit is idle.
  // --------------------------------------------------------------------------
  initial begin : main
    dir_row_t dir_tab [25];
    int       i;

    // Directed rows. Counts of Predicted are left to the predictor.
    dir_tab = '{
      '{8'h00, 4'd1, 48'h00},                  // low extreme passes through
      '{8'hFF, 4'd1, 48'hFF},                  // high extreme passes through
      '{8'hEF, 4'd0, 48'h0},                   // full-width digit one
      '{8'hBC, 4'd0, 48'h0},
      '{8'h91, 4'd1, 48'h31},
      '{8'hE3, 4'd0, 48'h0},                   // ideographic comma
      '{8'h80, 4'd0, 48'h0},
      '{8'h81, 4'd2, 48'h20_2C},
      '{8'hE3, 4'd0, 48'h0},                   // lead byte broken by a letter
      '{8'h41, 4'd2, 48'h41_E3},
      '{8'hEF, 4'd0, 48'h0},                   // wide lead taken as middle byte
      '{8'hEF, 4'd0, 48'h0},
      '{8'h0A, 4'd3, 48'h0A_EF_EF},            // line end flushes both held bytes
      '{8'hEF, 4'd0, 48'h0},                   // converted byte opens a sequence
      '{8'h20, 4'd0, 48'h0},
      '{8'h43, Predicted, 48'h0},
      '{8'h80, Predicted, 48'h0},
      '{8'h82, Predicted, 48'h0},
      '{8'hE3, 4'd0, 48'h0},                   // both stages held at a line end
      '{8'h80, 4'd0, 48'h0},
      '{8'hEF, 4'd0, 48'h0},
      '{8'h2C, 4'd0, 48'h0},
      '{8'h0A, 4'd6, 48'h0A_20_2C_EF_80_E3},   // most words from one input
      '{8'hE3, 4'd0, 48'h0},                   // leave sequences open across
      '{8'hEF, 4'd0, 48'h0}                    // the next register writes
    };

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (i = 0; i < 25; i++)
      send_word(dir_tab[i].data, dir_tab[i].count, dir_tab[i].words);
    drain_output();

    // Clear both enables with sequences half done: they must still complete.
    write_reg(RegDigitEn, 1'b0);
    write_reg(RegPunctEn, 1'b0);
    send_random_text(50);
    drain_output();

    write_reg(RegDigitEn, 1'b1);
    holds_asked++;                 // long receiver hold while input keeps coming
    send_random_text(50);
    drain_output();

    write_reg(RegDigitEn, 1'b0);
    write_reg(RegPunctEn, 1'b1);
    send_random_text(50);
    drain_output();

    write_reg(RegDigitEn, 1'b1);
    send_random_text(50);
    drain_output();

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && filtered_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
